// ----- rtl/etu_pkg.sv -----
package etu_pkg;

   localparam int WIDTH = 32;
   localparam int CNT_W = $clog2(WIDTH + 1);

   localparam logic [WIDTH-1:0] FIRST_DIVISOR = WIDTH'(2);
   localparam logic [WIDTH-1:0] ONE = WIDTH'(1);

   // command to the shared divider
   typedef struct packed {
      logic             start;
      logic [WIDTH-1:0] dividend;
      logic [WIDTH-1:0] divisor;
   } div_req_type;

   // divider answer, valid while done is high
   typedef struct packed {
      logic             done;
      logic [WIDTH-1:0] quot;
      logic [WIDTH-1:0] rem;
   } div_rsp_type;

   typedef enum logic [6:0] {
      S_IDLE  = 7'b0000001,
      S_LOOP  = 7'b0000010,
      S_STRIP = 7'b0000100,
      S_RESD  = 7'b0001000,
      S_FINAL = 7'b0010000,
      S_FDIV  = 7'b0100000,
      S_DONE  = 7'b1000000
   } state_type;

endpackage

// ----- rtl/etu_div.sv -----
module etu_div
   import etu_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  div_req_type div_req,
   output div_rsp_type div_rsp
);

   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [WIDTH-1:0] quo_ff, quo_in;
   logic [WIDTH-1:0] rem_ff, rem_in;
   logic [WIDTH-1:0] dvs_ff, dvs_in;

   logic [WIDTH:0] partial;
   logic [WIDTH:0] diff;
   logic           fits;

   // one restoring step per cycle
   assign partial = {rem_ff, quo_ff[WIDTH-1]};
   assign diff    = partial - {1'b0, dvs_ff};
   assign fits    = partial >= {1'b0, dvs_ff};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      if (div_req.start) begin
         busy_in = 1'b1;
         cnt_in  = CNT_W'(WIDTH);
         quo_in  = div_req.dividend;
         rem_in  = '0;
         dvs_in  = div_req.divisor;
      end else if (busy_ff) begin
         quo_in = {quo_ff[WIDTH-2:0], fits};
         rem_in = fits ? diff[WIDTH-1:0] : partial[WIDTH-1:0];
         cnt_in = cnt_ff - CNT_W'(1);
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
   end

   assign div_rsp.done = done_ff;
   assign div_rsp.quot = quo_ff;
   assign div_rsp.rem  = rem_ff;

endmodule

// ----- rtl/euler_totient_unit.sv -----
// channel | direction | handshake                     | payload
// req     | in        | req_valid / req_stall (out)   | req_number  [31:0]
// rsp     | out       | rsp_valid / rsp_stall (in)    | rsp_totient [31:0]
//
// One item at a time; req_stall is high from the transfer until the result
// is in the output register. Each trial divisor costs one pass of the shared
// serial divider, plus one pass per stripped factor and one for the result
// correction. The output register holds a result under rsp_stall while the
// next item is accepted. Synchronous reset clears all control state.
module euler_totient_unit
   import etu_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  logic [WIDTH-1:0] req_number,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output logic [WIDTH-1:0] rsp_totient
);

   state_type        state_ff, state_in;
   logic             issued_ff, issued_in;
   logic [WIDTH-1:0] rest_ff, rest_in;
   logic [WIDTH-1:0] res_ff, res_in;
   logic [WIDTH-1:0] d_ff, d_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [WIDTH-1:0] rsp_totient_ff, rsp_totient_in;

   div_req_type div_req;
   div_rsp_type div_rsp;
   logic        div_state;
   logic        out_free;

   etu_div u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   assign div_state = (state_ff == S_LOOP) || (state_ff == S_STRIP) ||
                      (state_ff == S_RESD) || (state_ff == S_FDIV);
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      div_req.start    = div_state && !issued_ff;
      div_req.dividend = rest_ff;
      div_req.divisor  = d_ff;
      case (state_ff)
         S_RESD: begin
            div_req.dividend = res_ff;
         end
         S_FDIV: begin
            div_req.dividend = res_ff;
            div_req.divisor  = rest_ff;
         end
         default: ;
      endcase
   end

   always_comb begin
      state_in       = state_ff;
      issued_in      = issued_ff;
      rest_in        = rest_ff;
      res_in         = res_ff;
      d_in           = d_ff;
      rsp_valid_in   = rsp_valid_ff && rsp_stall;
      rsp_totient_in = rsp_totient_ff;
      if (div_req.start) issued_in = 1'b1;
      if (div_rsp.done)  issued_in = 1'b0;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               rest_in  = req_number;
               res_in   = req_number;
               d_in     = FIRST_DIVISOR;
               state_in = S_LOOP;
            end
         end
         S_LOOP: begin
            // quotient below d means d*d > rest: trial phase over
            if (div_rsp.done) begin
               if (d_ff > div_rsp.quot) begin
                  state_in = S_FINAL;
               end else if (div_rsp.rem == '0) begin
                  rest_in  = div_rsp.quot;
                  state_in = S_STRIP;
               end else begin
                  d_in = d_ff + ONE;
               end
            end
         end
         S_STRIP: begin
            if (div_rsp.done) begin
               if (div_rsp.rem == '0) rest_in = div_rsp.quot;
               else                   state_in = S_RESD;
            end
         end
         S_RESD: begin
            if (div_rsp.done) begin
               res_in   = res_ff - div_rsp.quot;
               d_in     = d_ff + ONE;
               state_in = S_LOOP;
            end
         end
         S_FINAL: begin
            // leftover cofactor above one is a prime factor
            state_in = (rest_ff > ONE) ? S_FDIV : S_DONE;
         end
         S_FDIV: begin
            if (div_rsp.done) begin
               res_in   = res_ff - div_rsp.quot;
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            if (out_free) begin
               rsp_valid_in   = 1'b1;
               rsp_totient_in = res_ff;
               state_in       = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         issued_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         issued_ff    <= issued_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rest_ff        <= rest_in;
      res_ff         <= res_in;
      d_ff           <= d_in;
      rsp_totient_ff <= rsp_totient_in;
   end

   assign req_stall   = (state_ff != S_IDLE);
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_totient = rsp_totient_ff;

   a_done_when_issued: assert property (@(posedge clock) disable iff (reset)
      div_rsp.done |-> issued_ff)
      else $error("divider answer without a pending command");

   a_no_start_while_pending: assert property (@(posedge clock) disable iff (reset)
      issued_ff && !div_rsp.done |-> !div_req.start)
      else $error("divider restarted while busy");

   a_result_loaded: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DONE) && out_free |=> rsp_valid_ff && (state_ff == S_IDLE))
      else $error("finished result not moved to output register");

   a_divisor_nonzero: assert property (@(posedge clock) disable iff (reset)
      div_req.start |-> (div_req.divisor > ONE))
      else $error("divider started with divisor below two");

endmodule

// ----- test/totient_checker.sv -----
`timescale 1ns / 100ps

module totient_checker
   import etu_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   input  logic             req_stall,
   input  logic [WIDTH-1:0] req_number,
   input  logic             rsp_valid,
   input  logic             rsp_stall,
   input  logic [WIDTH-1:0] rsp_totient,
   output int               mismatches,
   output int               outstanding
);

   typedef struct packed {
      logic [WIDTH-1:0] number;
      logic [WIDTH-1:0] totient;
   } totient_entry_type;

   totient_entry_type expected_totients[$];

   // trial division; loop bound d <= rest/d keeps d*d from overflowing
   function automatic logic [WIDTH-1:0] phi_of(input logic [WIDTH-1:0] n);
      logic [WIDTH-1:0] rest;
      logic [WIDTH-1:0] acc;
      logic [WIDTH-1:0] d;
      rest = n;
      acc  = n;
      for (d = FIRST_DIVISOR; d <= rest / d; d++) begin
         if (rest % d == 0) begin
            while (rest % d == 0)
               rest = rest / d;
            acc = acc - acc / d;
         end
      end
      // leftover cofactor is a prime factor
      if (rest > ONE)
         acc = acc - acc / rest;
      return acc;
   endfunction

   always @(posedge clock) begin
      totient_entry_type head;
      totient_entry_type fresh;
      if (reset) begin
         expected_totients.delete();
         mismatches  <= 0;
         outstanding <= 0;
      end else begin
         // result side first so a transfer on an empty queue is flagged
         if (rsp_valid && !rsp_stall) begin
            if (expected_totients.size() == 0) begin
               $display("%0t: unexpected result transfer, expected none, actual totient %0d",
                        $time, rsp_totient);
               mismatches <= mismatches + 1;
            end else begin
               head = expected_totients.pop_front();
               if (rsp_totient !== head.totient) begin
                  $display("%0t: totient mismatch for n=%0d, expected %0d, actual %0d",
                           $time, head.number, head.totient, rsp_totient);
                  mismatches <= mismatches + 1;
               end
            end
         end
         if (req_valid && !req_stall) begin
            fresh.number      = req_number;
            fresh.totient     = phi_of(req_number);
            expected_totients = {expected_totients, fresh};
         end
         outstanding <= expected_totients.size();
      end
   end

endmodule

// ----- test/tb.sv -----
`timescale 1ns / 100ps

module tb
   import etu_pkg::*;
();

   localparam int RANDOM_ITEMS = 75;
   localparam int IDLE_PCT     = 8;
   localparam int STALL_LIMIT  = 10_000_000;
   localparam int NUM_DIRECTED = 25;

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             req_valid = 1'b0;
   logic             req_stall;
   logic [WIDTH-1:0] req_number = '0;
   logic             rsp_valid;
   logic             rsp_stall = 1'b0;
   logic [WIDTH-1:0] rsp_totient;

   int mismatches;
   int outstanding;
   bit quiet = 1'b0;
   int item;

   // edge cases: tiny values, primes, prime powers, large values with big prime factors
   logic [WIDTH-1:0] directed_numbers [NUM_DIRECTED] = '{
      32'd0, 32'd1, 32'd2, 32'd3, 32'd4, 32'd5, 32'd6, 32'd8, 32'd9, 32'd12,
      32'd36, 32'd97, 32'd210, 32'd4096,
      32'd1018081, 32'd1000003, 32'd4096012288, 32'd3486784401,
      32'd1013 * 32'd1019 * 32'd1021,
      32'hFFFF_FFFF, 32'hFFFF_FFFC, 32'h8000_0000, 32'hAAAA_AAAA, 32'h5555_5555,
      32'hFFFF_0000
   };

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   euler_totient_unit dut (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_number (req_number),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_totient(rsp_totient)
   );

   totient_checker u_checker (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_number (req_number),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_totient(rsp_totient),
      .mismatches (mismatches),
      .outstanding(outstanding)
   );

   always @(posedge clock) begin
      rsp_stall <= !quiet && ($urandom_range(99) < IDLE_PCT);
   end

   // operands chosen so the cofactor collapses fast; large primes would take far longer
   function automatic logic [WIDTH-1:0] pick_operand();
      int unsigned      sel;
      logic [WIDTH-1:0] m;
      sel = $urandom_range(99);
      if (sel < 55) begin
         return WIDTH'($urandom_range(4095));
      end else if (sel < 85) begin
         m = WIDTH'($urandom_range(4095, 1));
         return m << $urandom_range(WIDTH - 1);
      end else if (sel < 95) begin
         return WIDTH'($urandom) & 32'hFFF0_0000;
      end else begin
         return WIDTH'($urandom_range(1023, 2)) * WIDTH'($urandom_range(1023, 2))
                * WIDTH'($urandom_range(1023, 2));
      end
   endfunction

   task automatic send_number(input logic [WIDTH-1:0] n);
      if (!quiet) begin
         while ($urandom_range(99) < IDLE_PCT) begin
            req_valid <= 1'b0;
            @(posedge clock);
         end
      end
      req_valid  <= 1'b1;
      req_number <= n;
      @(posedge clock);
      while (req_stall)
         @(posedge clock);
   endtask

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      for (item = 0; item < NUM_DIRECTED; item++)
         send_number(directed_numbers[item]);

      // hold off until the block has drained
      req_valid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0)
         @(posedge clock);

      for (item = 0; item < RANDOM_ITEMS; item++) begin
         quiet <= (item >= 40 && item < 70);
         send_number(pick_operand());
      end
      req_valid <= 1'b0;
      quiet     <= 1'b0;

      @(posedge clock);
      while (outstanding != 0)
         @(posedge clock);
      repeat (100) @(posedge clock);

      if (mismatches == 0 && outstanding == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

   // watchdog: cycles without any transfer on either channel
   initial begin
      int unsigned idle_cycles;
      idle_cycles = 0;
      while (idle_cycles < STALL_LIMIT) begin
         @(posedge clock);
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
            idle_cycles = 0;
         else
            idle_cycles++;
      end
      $display("%0t: watchdog expired with %0d results outstanding", $time, outstanding);
      $display("Regression FAIL");
      $finish;
   end

endmodule
